>>> sv/rwsp_pkg.sv
// Shared types, constants and codes of the RIFF/WAVE stream parser.
package rwsp_pkg;

	// Width of the file byte counter
	localparam int LEN_BITS = 32;
	// Width used to compare the RIFF length with the byte count
	localparam int CMP_W = (LEN_BITS > 32) ? LEN_BITS : 32;

	// Output queue depth; one input word makes at most two results
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// Tags, big-endian as they arrive
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	// Smallest legal file and smallest fmt payload
	localparam logic [LEN_BITS-1:0] MIN_FILE_BYTES = LEN_BITS'(44);
	localparam logic [31:0] MIN_FMT_BYTES = 32'd16;
	localparam logic [4:0]  FMT_FIELD_BYTES = 5'd16;

	// Header byte positions
	localparam logic [3:0] IDX_RIFF_END = 4'd3;
	localparam logic [3:0] IDX_LEN_LO   = 4'd4;
	localparam logic [3:0] IDX_LEN_HI   = 4'd7;
	localparam logic [3:0] IDX_WAVE_END = 4'd11;

	// Positions of the bits-per-sample bytes in the fmt payload
	localparam logic [4:0] FMT_OFS_BITS_LO = 5'd14;
	localparam logic [4:0] FMT_OFS_BITS_HI = 5'd15;

	// Format codes
	localparam logic [15:0] FMT_CODE_PCM   = 16'd1;
	localparam logic [15:0] FMT_CODE_FLOAT = 16'd3;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CORRUPT = 2'd1;
	localparam logic [1:0] ST_MAGIC   = 2'd2;
	localparam logic [1:0] ST_UNSUP   = 2'd3;

	// Result kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_CHDR,
		PH_BODY,
		PH_PAD,
		PH_HALT
	} phase_t;

	typedef enum logic [1:0] {
		CT_OTHER,
		CT_FMT,
		CT_DATA
	} chunk_t;

	// One result word
	typedef struct packed {
		logic        kind;
		logic [7:0]  sample_byte;
		logic        chunk_first;
		logic [1:0]  status_code;
		logic        is_float;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [15:0] sample_bits;
		logic        run_end;
	} result_t;

	// Results of one parsed word, sample first
	typedef struct packed {
		logic    smp_vld;
		logic    sts_vld;
		result_t smp;
		result_t sts;
	} push_t;

endpackage

>>> sv/riff_wave_stream_parser.sv
// Top level of the RIFF/WAVE stream parser: input register, parser, result queue.
//
//   channel  direction  handshake           word
//   in       sink       in_valid/in_stall   byte_value, end_of_file
//   out      source     out_valid/out_stall kind, sample_byte, chunk_first, status_code,
//                                           is_float, channel_count, rate_hz,
//                                           sample_bits, run_end
//
// One file byte is taken per cycle while in_stall is low; its results pass from the input
// register through the parser into the result queue before they show at the output.
// Each byte is parsed once held and the queue has room for two words; the last byte of a file
// pushes its status word, together with its data word when it is payload, into the
// four-entry result queue.
// in_stall rises only when the queue holds more than two words and a byte waits to be parsed.
// Reset clears the parser to the start of a file; after each status word it returns there.
module riff_wave_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  sample_byte,
	output logic        chunk_first,
	output logic [1:0]  status_code,
	output logic        is_float,
	output logic [15:0] channel_count,
	output logic [31:0] rate_hz,
	output logic [15:0] sample_bits,
	output logic        run_end
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eof_s1;
	logic              go;
	logic              room2;
	logic              take;
	rwsp_pkg::push_t   push;
	rwsp_pkg::result_t head;

	// Parse the held word once the queue has room for two results
	assign go       = valid_s1 & room2;
	assign in_stall = valid_s1 & ~room2;
	assign take     = in_valid & ~in_stall;

	// Hold the input word until it is parsed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= byte_value;
			eof_s1  <= end_of_file;
		end
	end

	rwsp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.byte_in (byte_s1),
		.eof_in  (eof_s1),
		.push    (push)
	);

	rwsp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (~out_stall),
		.room2     (room2),
		.not_empty (out_valid),
		.head      (head)
	);

	// Drive the output word from the queue head
	assign kind          = head.kind;
	assign sample_byte   = head.sample_byte;
	assign chunk_first   = head.chunk_first;
	assign status_code   = head.status_code;
	assign is_float      = head.is_float;
	assign channel_count = head.channel_count;
	assign rate_hz       = head.rate_hz;
	assign sample_bits   = head.sample_bits;
	assign run_end       = head.run_end;

endmodule

>>> sv/rwsp_parse.sv
// Parser state and per-word result logic of the RIFF/WAVE stream parser.
module rwsp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [7:0]          byte_in,
	input  logic                eof_in,
	output rwsp_pkg::push_t     push
);

	logic [rwsp_pkg::LEN_BITS-1:0] byte_count_q;
	logic                          overflow_q;
	rwsp_pkg::phase_t              phase_q;
	logic [31:0]                   header_shift_q;
	logic [3:0]                    header_index_q;
	logic [31:0]                   riff_length_q;
	logic [31:0]                   chunk_remaining_q;
	rwsp_pkg::chunk_t              chunk_type_q;
	logic                          pad_pending_q;
	logic [4:0]                    fmt_offset_q;
	logic [63:0]                   fmt_shift_q;
	logic [15:0]                   pend_bits_q;
	logic                          data_first_q;
	logic                          seen_fmt_q;
	logic                          seen_data_q;
	logic [15:0]                   fmt_channels_q;
	logic [31:0]                   fmt_rate_q;
	logic [15:0]                   fmt_bits_q;
	logic                          fmt_float_q;
	logic                          magic_error_q;
	logic [1:0]                    first_err_q;
	logic [1:0]                    cur_err_q;

	logic [rwsp_pkg::LEN_BITS-1:0] byte_count_n;
	logic                          overflow_n;
	rwsp_pkg::phase_t              phase_n;
	logic [31:0]                   header_shift_n;
	logic [3:0]                    header_index_n;
	logic [31:0]                   riff_length_n;
	logic [31:0]                   chunk_remaining_n;
	rwsp_pkg::chunk_t              chunk_type_n;
	logic                          pad_pending_n;
	logic [4:0]                    fmt_offset_n;
	logic [63:0]                   fmt_shift_n;
	logic [15:0]                   pend_bits_n;
	logic                          data_first_n;
	logic                          seen_fmt_n;
	logic                          seen_data_n;
	logic [15:0]                   fmt_channels_n;
	logic [31:0]                   fmt_rate_n;
	logic [15:0]                   fmt_bits_n;
	logic                          fmt_float_n;
	logic                          magic_error_n;
	logic [1:0]                    first_err_n;
	logic [1:0]                    cur_err_n;

	logic        finish;
	logic [1:0]  fin_err;
	logic [15:0] fmt_enc;
	logic [15:0] fmt_ch;
	logic [31:0] fmt_rt;
	logic [1:0]  status;
	logic        status_ok;

	// Next parser state and results for the word in the input register
	always_comb begin
		byte_count_n      = byte_count_q + rwsp_pkg::LEN_BITS'(1);
		overflow_n        = overflow_q | (byte_count_n == '0);
		phase_n           = phase_q;
		header_shift_n    = header_shift_q;
		header_index_n    = header_index_q;
		riff_length_n     = riff_length_q;
		chunk_remaining_n = chunk_remaining_q;
		chunk_type_n      = chunk_type_q;
		pad_pending_n     = pad_pending_q;
		fmt_offset_n      = fmt_offset_q;
		fmt_shift_n       = fmt_shift_q;
		pend_bits_n       = pend_bits_q;
		data_first_n      = data_first_q;
		seen_fmt_n        = seen_fmt_q;
		seen_data_n       = seen_data_q;
		fmt_channels_n    = fmt_channels_q;
		fmt_rate_n        = fmt_rate_q;
		fmt_bits_n        = fmt_bits_q;
		fmt_float_n       = fmt_float_q;
		magic_error_n     = magic_error_q;
		first_err_n       = first_err_q;
		cur_err_n         = cur_err_q;
		finish            = 1'b0;
		fin_err           = rwsp_pkg::ST_OK;
		fmt_enc           = fmt_shift_n[15:0];
		fmt_ch            = fmt_shift_n[31:16];
		fmt_rt            = fmt_shift_n[63:32];
		status            = rwsp_pkg::ST_OK;
		status_ok         = 1'b0;
		push              = '0;

		case (phase_q)
			rwsp_pkg::PH_RIFF: begin
				header_shift_n = {header_shift_q[23:0], byte_in};
				if (header_index_q >= rwsp_pkg::IDX_LEN_LO &&
						header_index_q <= rwsp_pkg::IDX_LEN_HI) begin
					riff_length_n = riff_length_q |
						(32'(byte_in) << {header_index_q[1:0], 3'b000});
				end
				if (header_index_q == rwsp_pkg::IDX_RIFF_END &&
						header_shift_n != rwsp_pkg::TAG_RIFF) begin
					magic_error_n = 1'b1;
					phase_n       = rwsp_pkg::PH_HALT;
				end else if (header_index_q == rwsp_pkg::IDX_WAVE_END) begin
					header_index_n = '0;
					if (header_shift_n != rwsp_pkg::TAG_WAVE) begin
						magic_error_n = 1'b1;
						phase_n       = rwsp_pkg::PH_HALT;
					end else begin
						phase_n = rwsp_pkg::PH_CHDR;
					end
				end else begin
					header_index_n = header_index_q + 4'd1;
				end
			end
			rwsp_pkg::PH_CHDR: begin
				header_index_n = header_index_q + 4'd1;
				if (header_index_q < rwsp_pkg::IDX_LEN_LO) begin
					header_shift_n = {header_shift_q[23:0], byte_in};
					if (header_index_q == '0) begin
						chunk_remaining_n = '0;
					end
					if (header_index_q == rwsp_pkg::IDX_RIFF_END) begin
						if (header_shift_n == rwsp_pkg::TAG_FMT) begin
							chunk_type_n = rwsp_pkg::CT_FMT;
						end else if (header_shift_n == rwsp_pkg::TAG_DATA) begin
							chunk_type_n = rwsp_pkg::CT_DATA;
						end else begin
							chunk_type_n = rwsp_pkg::CT_OTHER;
						end
					end
				end else begin
					chunk_remaining_n = chunk_remaining_q |
						(32'(byte_in) << {header_index_q[1:0], 3'b000});
					if (header_index_q >= rwsp_pkg::IDX_LEN_HI) begin
						pad_pending_n = chunk_remaining_n[0];
						cur_err_n     = rwsp_pkg::ST_OK;
						if (chunk_type_q == rwsp_pkg::CT_FMT &&
								chunk_remaining_n < rwsp_pkg::MIN_FMT_BYTES) begin
							cur_err_n = rwsp_pkg::ST_CORRUPT;
						end
						if (chunk_type_q == rwsp_pkg::CT_DATA && !seen_fmt_q) begin
							cur_err_n = rwsp_pkg::ST_CORRUPT;
						end
						fmt_offset_n = '0;
						fmt_shift_n  = '0;
						pend_bits_n  = '0;
						data_first_n = 1'b1;
						if (chunk_remaining_n == '0) begin
							finish = 1'b1;
						end else begin
							phase_n = rwsp_pkg::PH_BODY;
						end
					end
				end
			end
			rwsp_pkg::PH_BODY: begin
				// Stream data payload
				if (chunk_type_q == rwsp_pkg::CT_DATA && cur_err_q == rwsp_pkg::ST_OK) begin
					push.smp_vld         = 1'b1;
					push.smp.kind        = rwsp_pkg::KIND_SAMPLE;
					push.smp.sample_byte = byte_in;
					push.smp.chunk_first = data_first_q;
					push.smp.run_end     = ~eof_in;
					data_first_n         = 1'b0;
				end
				// Capture the fixed fmt fields
				if (chunk_type_q == rwsp_pkg::CT_FMT &&
						fmt_offset_q < rwsp_pkg::FMT_FIELD_BYTES) begin
					if (!fmt_offset_q[4] && !fmt_offset_q[3]) begin
						fmt_shift_n = fmt_shift_q |
							(64'(byte_in) << {fmt_offset_q[2:0], 3'b000});
					end else if (fmt_offset_q == rwsp_pkg::FMT_OFS_BITS_LO) begin
						pend_bits_n = pend_bits_q | 16'(byte_in);
					end else if (fmt_offset_q == rwsp_pkg::FMT_OFS_BITS_HI) begin
						pend_bits_n = pend_bits_q | {byte_in, 8'h00};
					end
					fmt_offset_n = fmt_offset_q + 5'd1;
				end
				chunk_remaining_n = chunk_remaining_q - 32'd1;
				if (chunk_remaining_n == '0) begin
					finish = 1'b1;
				end
			end
			rwsp_pkg::PH_PAD: begin
				phase_n        = rwsp_pkg::PH_CHDR;
				header_index_n = '0;
			end
			default: begin
			end
		endcase

		// Close a finished chunk
		fmt_enc  = fmt_shift_n[15:0];
		fmt_ch   = fmt_shift_n[31:16];
		fmt_rt   = fmt_shift_n[63:32];
		if (finish) begin
			fin_err = cur_err_n;
			if (fin_err == rwsp_pkg::ST_OK && chunk_type_n == rwsp_pkg::CT_FMT) begin
				if (fmt_enc != rwsp_pkg::FMT_CODE_PCM &&
						fmt_enc != rwsp_pkg::FMT_CODE_FLOAT) begin
					fin_err = rwsp_pkg::ST_UNSUP;
				end else if (fmt_ch == '0 || fmt_rt == '0 || pend_bits_n == '0 ||
						pend_bits_n[2:0] != 3'd0) begin
					fin_err = rwsp_pkg::ST_CORRUPT;
				end else begin
					fmt_channels_n = fmt_ch;
					fmt_rate_n     = fmt_rt;
					fmt_bits_n     = pend_bits_n;
					fmt_float_n    = (fmt_enc == rwsp_pkg::FMT_CODE_FLOAT);
					seen_fmt_n     = 1'b1;
				end
			end
			if (fin_err == rwsp_pkg::ST_OK && chunk_type_n == rwsp_pkg::CT_DATA) begin
				seen_data_n = 1'b1;
			end
			if (fin_err != rwsp_pkg::ST_OK) begin
				first_err_n = fin_err;
				phase_n     = rwsp_pkg::PH_HALT;
			end else begin
				phase_n        = pad_pending_n ? rwsp_pkg::PH_PAD : rwsp_pkg::PH_CHDR;
				header_index_n = '0;
			end
		end

		// Rank file errors for the closing status word
		if (overflow_n || byte_count_n < rwsp_pkg::MIN_FILE_BYTES) begin
			status = rwsp_pkg::ST_CORRUPT;
		end else if (magic_error_n) begin
			status = rwsp_pkg::ST_MAGIC;
		end else if (rwsp_pkg::CMP_W'(riff_length_n) > rwsp_pkg::CMP_W'(byte_count_n)) begin
			status = rwsp_pkg::ST_CORRUPT;
		end else if (first_err_n != rwsp_pkg::ST_OK) begin
			status = first_err_n;
		end else if (phase_n == rwsp_pkg::PH_BODY) begin
			status = rwsp_pkg::ST_CORRUPT;
		end else if (!seen_fmt_n || !seen_data_n) begin
			status = rwsp_pkg::ST_CORRUPT;
		end else begin
			status = rwsp_pkg::ST_OK;
		end
		status_ok = (status == rwsp_pkg::ST_OK);

		push.sts_vld           = eof_in;
		push.sts.kind          = rwsp_pkg::KIND_STATUS;
		push.sts.status_code   = status;
		push.sts.is_float      = status_ok & fmt_float_n;
		push.sts.channel_count = status_ok ? fmt_channels_n : 16'd0;
		push.sts.rate_hz       = status_ok ? fmt_rate_n : 32'd0;
		push.sts.sample_bits   = status_ok ? fmt_bits_n : 16'd0;
		push.sts.run_end       = 1'b1;

		// Drop results when no word is parsed
		push.smp_vld = push.smp_vld & go;
		push.sts_vld = push.sts_vld & go;
	end

	// Advance parser state; return to reset state after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q      <= '0;
			overflow_q        <= 1'b0;
			phase_q           <= rwsp_pkg::PH_RIFF;
			header_shift_q    <= '0;
			header_index_q    <= '0;
			riff_length_q     <= '0;
			chunk_remaining_q <= '0;
			chunk_type_q      <= rwsp_pkg::CT_OTHER;
			pad_pending_q     <= 1'b0;
			fmt_offset_q      <= '0;
			fmt_shift_q       <= '0;
			pend_bits_q       <= '0;
			data_first_q      <= 1'b0;
			seen_fmt_q        <= 1'b0;
			seen_data_q       <= 1'b0;
			fmt_channels_q    <= '0;
			fmt_rate_q        <= '0;
			fmt_bits_q        <= '0;
			fmt_float_q       <= 1'b0;
			magic_error_q     <= 1'b0;
			first_err_q       <= rwsp_pkg::ST_OK;
			cur_err_q         <= rwsp_pkg::ST_OK;
		end else if (go && eof_in) begin
			byte_count_q      <= '0;
			overflow_q        <= 1'b0;
			phase_q           <= rwsp_pkg::PH_RIFF;
			header_shift_q    <= '0;
			header_index_q    <= '0;
			riff_length_q     <= '0;
			chunk_remaining_q <= '0;
			chunk_type_q      <= rwsp_pkg::CT_OTHER;
			pad_pending_q     <= 1'b0;
			fmt_offset_q      <= '0;
			fmt_shift_q       <= '0;
			pend_bits_q       <= '0;
			data_first_q      <= 1'b0;
			seen_fmt_q        <= 1'b0;
			seen_data_q       <= 1'b0;
			fmt_channels_q    <= '0;
			fmt_rate_q        <= '0;
			fmt_bits_q        <= '0;
			fmt_float_q       <= 1'b0;
			magic_error_q     <= 1'b0;
			first_err_q       <= rwsp_pkg::ST_OK;
			cur_err_q         <= rwsp_pkg::ST_OK;
		end else if (go) begin
			byte_count_q      <= byte_count_n;
			overflow_q        <= overflow_n;
			phase_q           <= phase_n;
			header_shift_q    <= header_shift_n;
			header_index_q    <= header_index_n;
			riff_length_q     <= riff_length_n;
			chunk_remaining_q <= chunk_remaining_n;
			chunk_type_q      <= chunk_type_n;
			pad_pending_q     <= pad_pending_n;
			fmt_offset_q      <= fmt_offset_n;
			fmt_shift_q       <= fmt_shift_n;
			pend_bits_q       <= pend_bits_n;
			data_first_q      <= data_first_n;
			seen_fmt_q        <= seen_fmt_n;
			seen_data_q       <= seen_data_n;
			fmt_channels_q    <= fmt_channels_n;
			fmt_rate_q        <= fmt_rate_n;
			fmt_bits_q        <= fmt_bits_n;
			fmt_float_q       <= fmt_float_n;
			magic_error_q     <= magic_error_n;
			first_err_q       <= first_err_n;
			cur_err_q         <= cur_err_n;
		end
	end

endmodule

>>> sv/rwsp_outq.sv
// Result queue of the RIFF/WAVE stream parser: takes up to two words a cycle.
module rwsp_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  rwsp_pkg::push_t   push,
	input  logic              pop,
	output logic              room2,
	output logic              not_empty,
	output rwsp_pkg::result_t head
);

	rwsp_pkg::result_t             mem_q [rwsp_pkg::OQ_DEPTH];
	logic [rwsp_pkg::OQ_PTR_W-1:0] wr_ptr_q;
	logic [rwsp_pkg::OQ_PTR_W-1:0] rd_ptr_q;
	logic [rwsp_pkg::OQ_CNT_W-1:0] count_q;
	logic [rwsp_pkg::OQ_PTR_W-1:0] sts_ptr;
	logic [rwsp_pkg::OQ_CNT_W-1:0] n_push;
	logic                          do_pop;

	assign sts_ptr   = wr_ptr_q + rwsp_pkg::OQ_PTR_W'(push.smp_vld);
	assign n_push    = rwsp_pkg::OQ_CNT_W'(push.smp_vld) + rwsp_pkg::OQ_CNT_W'(push.sts_vld);
	assign not_empty = (count_q != '0);
	assign do_pop    = pop & not_empty;
	assign room2     = (count_q <= rwsp_pkg::OQ_CNT_W'(rwsp_pkg::OQ_DEPTH - 2));
	assign head      = mem_q[rd_ptr_q];

	// Write sample word first, status word behind it
	always_ff @(posedge clk) begin
		if (push.smp_vld) begin
			mem_q[wr_ptr_q] <= push.smp;
		end
		if (push.sts_vld) begin
			mem_q[sts_ptr] <= push.sts;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + rwsp_pkg::OQ_PTR_W'(n_push);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + rwsp_pkg::OQ_PTR_W'(1);
			end
			count_q <= count_q + n_push - rwsp_pkg::OQ_CNT_W'(do_pop);
		end
	end

endmodule

>>> tb/testbench.sv
// Self-checking testbench of the RIFF/WAVE stream parser: file stimulus, predictor, scoreboard.
module testbench;

	localparam int RANDOM_BYTES = 500;
	localparam int HOLD_CYCLES  = 120;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam logic [31:0] TAG_LIST = 32'h4c49_5354;

	// Mirror of the parser: predicts the result words caused by each file byte
	class wav_parse_board;
		rwsp_pkg::result_t owed_results[$];
		int errors;

		logic [rwsp_pkg::LEN_BITS-1:0] n_bytes;
		bit wrapped;
		rwsp_pkg::phase_t phase;
		logic [31:0] tag_sr;
		logic [3:0] hdr_pos;
		logic [31:0] riff_len;
		logic [31:0] left;
		rwsp_pkg::chunk_t ctype;
		bit pad_due;
		logic [4:0] fmt_pos;
		logic [63:0] fmt_sr;
		logic [15:0] bits_acc;
		bit first_due, fmt_taken, data_taken, tag_bad, flt;
		logic [15:0] chans, width;
		logic [31:0] rate;
		logic [1:0] first_err, cur_err;

		function new();
			errors = 0;
			clear();
		endfunction

		// Return to the start of a file
		function void clear();
			n_bytes = '0;
			wrapped = 1'b0;
			phase = rwsp_pkg::PH_RIFF;
			tag_sr = '0;
			hdr_pos = '0;
			riff_len = '0;
			left = '0;
			ctype = rwsp_pkg::CT_OTHER;
			pad_due = 1'b0;
			fmt_pos = '0;
			fmt_sr = '0;
			bits_acc = '0;
			first_due = 1'b0;
			fmt_taken = 1'b0;
			data_taken = 1'b0;
			tag_bad = 1'b0;
			flt = 1'b0;
			chans = '0;
			width = '0;
			rate = '0;
			first_err = rwsp_pkg::ST_OK;
			cur_err = rwsp_pkg::ST_OK;
		endfunction

		// Close a chunk: validate fmt fields, latch errors, pick the next phase
		function void close_chunk();
			logic [1:0] err;
			logic [15:0] code, ch;
			logic [31:0] rt;
			err = cur_err;
			if (err == rwsp_pkg::ST_OK && ctype == rwsp_pkg::CT_FMT) begin
				code = fmt_sr[15:0];
				ch = fmt_sr[31:16];
				rt = fmt_sr[63:32];
				if (code != rwsp_pkg::FMT_CODE_PCM && code != rwsp_pkg::FMT_CODE_FLOAT)
					err = rwsp_pkg::ST_UNSUP;
				else if (ch == 0 || rt == 0 || bits_acc == 0 || bits_acc[2:0] != 0)
					err = rwsp_pkg::ST_CORRUPT;
				else begin
					chans = ch;
					rate = rt;
					width = bits_acc;
					flt = (code == rwsp_pkg::FMT_CODE_FLOAT);
					fmt_taken = 1'b1;
				end
			end
			if (err == rwsp_pkg::ST_OK && ctype == rwsp_pkg::CT_DATA)
				data_taken = 1'b1;
			if (err != rwsp_pkg::ST_OK) begin
				first_err = err;
				phase = rwsp_pkg::PH_HALT;
			end else begin
				phase = pad_due ? rwsp_pkg::PH_PAD : rwsp_pkg::PH_CHDR;
				hdr_pos = '0;
			end
		endfunction

		// Advance the parser by one accepted word and queue what it emits
		function void parse_byte(logic [7:0] b, logic eof);
			rwsp_pkg::result_t r;
			logic [1:0] st;
			logic [3:0] idx;
			idx = hdr_pos;
			n_bytes = n_bytes + rwsp_pkg::LEN_BITS'(1);
			if (n_bytes == '0)
				wrapped = 1'b1;
			case (phase)
				rwsp_pkg::PH_RIFF: begin
					tag_sr = {tag_sr[23:0], b};
					if (idx >= rwsp_pkg::IDX_LEN_LO && idx <= rwsp_pkg::IDX_LEN_HI)
						riff_len |= 32'(b) << (8 * (idx - rwsp_pkg::IDX_LEN_LO));
					if (idx == rwsp_pkg::IDX_RIFF_END && tag_sr != rwsp_pkg::TAG_RIFF) begin
						tag_bad = 1'b1;
						phase = rwsp_pkg::PH_HALT;
					end else if (idx == rwsp_pkg::IDX_WAVE_END) begin
						hdr_pos = '0;
						if (tag_sr != rwsp_pkg::TAG_WAVE) begin
							tag_bad = 1'b1;
							phase = rwsp_pkg::PH_HALT;
						end else
							phase = rwsp_pkg::PH_CHDR;
					end else
						hdr_pos = idx + 4'd1;
				end
				rwsp_pkg::PH_CHDR: begin
					if (idx < rwsp_pkg::IDX_LEN_LO) begin
						tag_sr = {tag_sr[23:0], b};
						if (idx == 0)
							left = '0;
						if (idx == rwsp_pkg::IDX_RIFF_END)
							ctype = (tag_sr == rwsp_pkg::TAG_FMT) ? rwsp_pkg::CT_FMT :
								((tag_sr == rwsp_pkg::TAG_DATA) ? rwsp_pkg::CT_DATA :
								rwsp_pkg::CT_OTHER);
						hdr_pos = idx + 4'd1;
					end else begin
						left |= 32'(b) << (8 * (idx - rwsp_pkg::IDX_LEN_LO));
						hdr_pos = idx + 4'd1;
						if (idx >= rwsp_pkg::IDX_LEN_HI) begin
							pad_due = left[0];
							cur_err = rwsp_pkg::ST_OK;
							if (ctype == rwsp_pkg::CT_FMT && left < rwsp_pkg::MIN_FMT_BYTES)
								cur_err = rwsp_pkg::ST_CORRUPT;
							if (ctype == rwsp_pkg::CT_DATA && !fmt_taken)
								cur_err = rwsp_pkg::ST_CORRUPT;
							fmt_pos = '0;
							fmt_sr = '0;
							bits_acc = '0;
							first_due = 1'b1;
							if (left == 0)
								close_chunk();
							else
								phase = rwsp_pkg::PH_BODY;
						end
					end
				end
				rwsp_pkg::PH_BODY: begin
					if (ctype == rwsp_pkg::CT_DATA && cur_err == rwsp_pkg::ST_OK) begin
						r = '0;
						r.kind = rwsp_pkg::KIND_SAMPLE;
						r.sample_byte = b;
						r.chunk_first = first_due;
						r.run_end = !eof;
						owed_results.push_back(r);
						first_due = 1'b0;
					end
					if (ctype == rwsp_pkg::CT_FMT && fmt_pos < rwsp_pkg::FMT_FIELD_BYTES) begin
						// first eight bytes: code, channels, rate
						if (fmt_pos < 5'd8)
							fmt_sr |= 64'(b) << (8 * fmt_pos);
						else if (fmt_pos == rwsp_pkg::FMT_OFS_BITS_LO)
							bits_acc |= {8'h00, b};
						else if (fmt_pos == rwsp_pkg::FMT_OFS_BITS_HI)
							bits_acc |= {b, 8'h00};
						fmt_pos = fmt_pos + 5'd1;
					end
					left = left - 32'd1;
					if (left == 0)
						close_chunk();
				end
				rwsp_pkg::PH_PAD: begin
					phase = rwsp_pkg::PH_CHDR;
					hdr_pos = '0;
				end
				default: ;
			endcase

			// Last byte: apply the status priority, then start over
			if (eof) begin
				if (wrapped || n_bytes < rwsp_pkg::MIN_FILE_BYTES)
					st = rwsp_pkg::ST_CORRUPT;
				else if (tag_bad)
					st = rwsp_pkg::ST_MAGIC;
				else if (riff_len > n_bytes)
					st = rwsp_pkg::ST_CORRUPT;
				else if (first_err != rwsp_pkg::ST_OK)
					st = first_err;
				else if (phase == rwsp_pkg::PH_BODY)
					st = rwsp_pkg::ST_CORRUPT;
				else if (!fmt_taken || !data_taken)
					st = rwsp_pkg::ST_CORRUPT;
				else
					st = rwsp_pkg::ST_OK;
				r = '0;
				r.kind = rwsp_pkg::KIND_STATUS;
				r.status_code = st;
				if (st == rwsp_pkg::ST_OK) begin
					r.is_float = flt;
					r.channel_count = chans;
					r.rate_hz = rate;
					r.sample_bits = width;
				end
				r.run_end = 1'b1;
				owed_results.push_back(r);
				clear();
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			end
		endfunction

		// Match an accepted result word against the oldest prediction
		function void check_result(rwsp_pkg::result_t got);
			rwsp_pkg::result_t want;
			if (owed_results.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, expected none got %h",
					$time, got);
				return;
			end
			want = owed_results.pop_front();
			compare_field("kind", 32'(want.kind), 32'(got.kind));
			compare_field("sample_byte", 32'(want.sample_byte), 32'(got.sample_byte));
			compare_field("chunk_first", 32'(want.chunk_first), 32'(got.chunk_first));
			compare_field("status_code", 32'(want.status_code), 32'(got.status_code));
			compare_field("is_float", 32'(want.is_float), 32'(got.is_float));
			compare_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
			compare_field("rate_hz", want.rate_hz, got.rate_hz);
			compare_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
			compare_field("run_end", 32'(want.run_end), 32'(got.run_end));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  byte_value = 8'h00;
	logic        end_of_file = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [7:0]  sample_byte;
	logic        chunk_first;
	logic [1:0]  status_code;
	logic        is_float;
	logic [15:0] channel_count;
	logic [31:0] rate_hz;
	logic [15:0] sample_bits;
	logic        run_end;

	wav_parse_board board;
	logic [7:0] img[$];
	int sent = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	riff_wave_stream_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_value(byte_value),
		.end_of_file(end_of_file),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.sample_byte(sample_byte),
		.chunk_first(chunk_first),
		.status_code(status_code),
		.is_float(is_float),
		.channel_count(channel_count),
		.rate_hz(rate_hz),
		.sample_bits(sample_bits),
		.run_end(run_end)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stall the output at random, or hold it off for a long stretch on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Check each accepted result word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result({kind, sample_byte, chunk_first, status_code, is_float,
				channel_count, rate_hz, sample_bits, run_end});
	end

	// Abort when neither side moves a word for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL riff_wave_stream_parser");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic logic [31:0] pick_span(logic [31:0] lo, logic [31:0] hi);
		case ($urandom_range(3))
			0: return lo;
			1: return hi;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	function automatic void put_tag(logic [31:0] t);
		for (int i = 3; i >= 0; i--)
			img.push_back(t[8*i +: 8]);
	endfunction

	function automatic void put_le(logic [31:0] v, int n);
		for (int i = 0; i < n; i++)
			img.push_back(v[8*i +: 8]);
	endfunction

	function automatic void put_noise(int n);
		for (int i = 0; i < n; i++)
			img.push_back(8'($urandom));
	endfunction

	// Chunk with a random payload of n bytes and a pad byte when size is odd
	function automatic void put_chunk(logic [31:0] tag, int size, int n);
		put_tag(tag);
		put_le(size, 4);
		put_noise(n);
		if (size % 2)
			put_noise(1);
	endfunction

	function automatic void put_fmt(logic [15:0] code, logic [15:0] ch, logic [31:0] rt,
		logic [15:0] bits, int size);
		logic [127:0] fields;
		fields = {bits, 16'($urandom), 32'($urandom), rt, ch, code};
		put_tag(rwsp_pkg::TAG_FMT);
		put_le(size, 4);
		for (int i = 0; i < size && i < 16; i++)
			img.push_back(fields[8*i +: 8]);
		if (size > 16)
			put_noise(size - 16);
		if (size % 2)
			put_noise(1);
	endfunction

	// Build one file image; each variant aims at one part of the format
	function automatic void build_file(int variant);
		int sub, n, cut;
		logic [15:0] code, ch, bits;
		logic [31:0] rt, len;
		sub = $urandom_range(3);
		n = $urandom_range(9);
		code = $urandom_range(1) ? rwsp_pkg::FMT_CODE_FLOAT : rwsp_pkg::FMT_CODE_PCM;
		ch = 16'(pick_span(1, 16'hFFFF));
		rt = pick_span(1, 32'hFFFF_FFFF);
		bits = 16'(pick_span(1, 8191) * 8);
		img.delete();
		put_tag(rwsp_pkg::TAG_RIFF);
		put_le(0, 4);
		put_tag(rwsp_pkg::TAG_WAVE);
		case (variant)
			0: begin
				put_fmt(code, ch, rt, bits, 16);
				put_chunk(rwsp_pkg::TAG_DATA, n, n);
			end
			1: begin
				// odd side chunk, long fmt, empty-ish data, new fmt, odd data
				put_chunk(TAG_LIST, 2 * $urandom_range(3) + 1, 0);
				img.delete();
				put_tag(rwsp_pkg::TAG_RIFF);
				put_le(0, 4);
				put_tag(rwsp_pkg::TAG_WAVE);
				n = 2 * $urandom_range(3) + 1;
				put_chunk(TAG_LIST, n, n);
				put_fmt(rwsp_pkg::FMT_CODE_FLOAT, ch, rt, bits, 16 + $urandom_range(3));
				put_chunk(rwsp_pkg::TAG_DATA, $urandom_range(4), 0);
				img.delete();
				put_tag(rwsp_pkg::TAG_RIFF);
				put_le(0, 4);
				put_tag(rwsp_pkg::TAG_WAVE);
				put_chunk(TAG_LIST, n, n);
				put_fmt(rwsp_pkg::FMT_CODE_FLOAT, ch, rt, bits, 16 + $urandom_range(3));
				cut = $urandom_range(4);
				put_chunk(rwsp_pkg::TAG_DATA, cut, cut);
				put_fmt(rwsp_pkg::FMT_CODE_PCM, 16'(pick_span(1, 16'hFFFF)),
					$urandom_range(48000, 1), 16'(8 * $urandom_range(4, 1)), 16);
				n = 2 * $urandom_range(4) + 1;
				put_chunk(rwsp_pkg::TAG_DATA, n, n);
				// drop the final pad byte now and then
				if (sub == 0)
					void'(img.pop_back());
			end
			2: begin
				put_chunk(rwsp_pkg::TAG_DATA, n + 1, n + 1);
				put_fmt(code, ch, rt, bits, 16);
				put_chunk(rwsp_pkg::TAG_DATA, n, n);
			end
			3: begin
				do
					code = 16'(pick_span(0, 16'hFFFF));
				while (code == rwsp_pkg::FMT_CODE_PCM || code == rwsp_pkg::FMT_CODE_FLOAT);
				put_fmt(code, ch, rt, bits, 16);
				put_chunk(rwsp_pkg::TAG_DATA, n, n);
			end
			4: begin
				case (sub)
					0: put_fmt(code, ch, rt, bits, $urandom_range(15));
					1: put_fmt(code, 16'd0, rt, bits, 16);
					2: put_fmt(code, ch, 32'd0, bits, 16);
					default: put_fmt(code, ch, rt,
						$urandom_range(1) ? 16'd0 : (bits | 16'($urandom_range(7, 1))), 16);
				endcase
				put_chunk(rwsp_pkg::TAG_DATA, n, n);
				put_noise($urandom_range(6));
			end
			5: begin
				put_fmt(code, ch, rt, bits, 16);
				put_chunk(rwsp_pkg::TAG_DATA, n, n);
				if (sub == 0) begin
					// chunk header cut short
					put_chunk(rwsp_pkg::TAG_DATA, n, 0);
					if (n % 2)
						void'(img.pop_back());
					repeat ($urandom_range(7, 1))
						void'(img.pop_back());
				end else if (sub == 1)
					put_chunk(rwsp_pkg::TAG_DATA, n + $urandom_range(20, 1), n);
				else
					put_chunk(TAG_LIST, n, n);
			end
			6: begin
				put_fmt(code, ch, rt, bits, 16);
				put_chunk(rwsp_pkg::TAG_DATA, n, n);
			end
			7: begin
				img.delete();
				put_noise($urandom_range(60, 1));
			end
			default: begin
				put_fmt(code, ch, rt, bits, 16);
				put_chunk(rwsp_pkg::TAG_DATA, n, n);
			end
		endcase

		// Patch the RIFF length, then apply header and length defects
		if (variant != 7) begin
			len = img.size() - 8;
			if (variant == 6 && sub == 0)
				len = len + $urandom_range(1000, 9);
			for (int i = 0; i < 4; i++)
				img[4 + i] = len[8*i +: 8];
			if (variant == 6 && sub == 1)
				img[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
			if (variant == 6 && sub >= 2)
				img[$urandom_range(11, 8)] ^= 8'(1 << $urandom_range(7));
			if (variant == 8) begin
				cut = $urandom_range(43, 1);
				while (img.size() > cut)
					void'(img.pop_back());
			end
		end
	endfunction

	// Offer one word; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic eof);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		end_of_file <= eof;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.parse_byte(b, eof);
		@(negedge clk);
	endtask

	task automatic send_file();
		for (int i = 0; i < img.size(); i++)
			send_byte(img[i], i == img.size() - 1);
		sent += img.size();
	endtask

	initial begin
		int k;
		board = new();
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Tiny broken files: lone bytes, bad tag, bare header
		img.delete();
		img.push_back(8'hFF);
		send_file();
		img.delete();
		img.push_back(8'h00);
		send_file();
		img.delete();
		put_tag(rwsp_pkg::TAG_RIFF ^ 32'h0000_0080);
		put_noise(2);
		send_file();
		img.delete();
		put_tag(rwsp_pkg::TAG_RIFF);
		put_le(32'hFFFF_FFFF, 4);
		put_tag(rwsp_pkg::TAG_WAVE);
		send_file();

		// Random files, rotating through idling phases
		k = 0;
		while (sent < RANDOM_BYTES) begin
			case (k % 5)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct = 51;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 51;
				end
				3: begin
					idle_pct = 28;
					stall_pct <= 28;
				end
				default: begin
					// back up the output while input keeps coming
					idle_pct = 0;
					stall_pct <= 0;
					hold_req <= ~hold_req;
				end
			endcase
			build_file(k % 9);
			send_file();
			k++;
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (board.owed_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		if (board.errors == 0 && board.owed_results.size() == 0)
			$display("PASS riff_wave_stream_parser");
		else
			$display("FAIL riff_wave_stream_parser");
		$finish;
	end
endmodule
